>>> rtl/core/imm_pkg.sv
// Shared types, constants, microcode table and helpers for the integer matrix multiply unit.
package imm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int DATA_WIDTH  = 32;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    localparam logic OP_ELEM_A = 1'b0;
    localparam logic OP_ELEM_B = 1'b1;

    // Microprogram steps
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_EMIT,
        ST_NEXT
    } t_step;

    // Jump conditions
    typedef enum logic [1:0] {
        C_ALWAYS,
        C_NO_TRIG,
        C_K_MORE,
        C_LAST
    } t_cond;

    typedef struct packed {
        logic in_ready;
        logic init;
        logic rd;
        logic mul;
        logic acc;
        logic emit;
        logic advance;
    } t_ctrl;

    typedef struct packed {
        t_cond cond;
        t_step target;
        logic  wait_out;
        t_ctrl ctrl;
    } t_uword;

    typedef struct packed {
        logic trig;
        logic k_more;
        logic last;
        logic out_busy;
    } t_status;

    typedef struct packed {
        logic [DIM_W-1:0] r;
        logic [DIM_W-1:0] n;
        logic [DIM_W-1:0] c;
    } t_dims;

    typedef struct packed {
        logic                         opcode;
        logic signed [DATA_WIDTH-1:0] element;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] product_value;
        logic [IDX_W-1:0]             out_row;
        logic [IDX_W-1:0]             out_col;
        logic                         last;
    } t_out_item;

    // Zero acts as one, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = v;
        end
        return d;
    endfunction

    // Control store: one word per step
    function automatic t_uword ucode_rom(input t_step s);
        t_uword uw;
        uw = '0;
        unique case (s)
            ST_IDLE: begin
                uw.ctrl.in_ready = 1'b1;
                uw.cond          = C_NO_TRIG;
                uw.target        = ST_IDLE;
            end
            ST_START: begin
                uw.ctrl.init = 1'b1;
                uw.cond      = C_ALWAYS;
                uw.target    = ST_READ;
            end
            ST_READ: begin
                uw.ctrl.rd = 1'b1;
                uw.cond    = C_ALWAYS;
                uw.target  = ST_MUL;
            end
            ST_MUL: begin
                uw.ctrl.mul = 1'b1;
                uw.cond     = C_ALWAYS;
                uw.target   = ST_ACC;
            end
            ST_ACC: begin
                uw.ctrl.acc = 1'b1;
                uw.cond     = C_K_MORE;
                uw.target   = ST_READ;
            end
            ST_EMIT: begin
                uw.ctrl.emit = 1'b1;
                uw.wait_out  = 1'b1;
                uw.cond      = C_LAST;
                uw.target    = ST_IDLE;
            end
            ST_NEXT: begin
                uw.ctrl.advance = 1'b1;
                uw.cond         = C_ALWAYS;
                uw.target       = ST_READ;
            end
            default: begin
                uw.cond   = C_ALWAYS;
                uw.target = ST_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

>>> rtl/core/imm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/imm_sequencer.sv
// Microcode sequencer: step counter, control store fetch and conditional jumps.
module imm_sequencer import imm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   stall;

    assign uw    = ucode_rom(r_step);
    assign stall = uw.wait_out && i_status.out_busy;

    // next step
    always_comb begin
        n_step = r_step;
        if (!stall) begin
            unique case (uw.cond)
                C_ALWAYS:  n_step = uw.target;
                C_NO_TRIG: n_step = i_status.trig   ? t_step'(r_step + 3'd1) : uw.target;
                C_K_MORE:  n_step = i_status.k_more ? uw.target : t_step'(r_step + 3'd1);
                C_LAST:    n_step = i_status.last   ? uw.target : t_step'(r_step + 3'd1);
                default:   n_step = ST_IDLE;
            endcase
        end
    end

    // control outputs
    always_comb begin
        o_ctrl = uw.ctrl;
        if (stall) begin
            o_ctrl.emit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> rtl/core/imm_datapath.sv
// Datapath: element stores, load counters, index walk, multiply-accumulate, result register.
module imm_datapath import imm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl     i_ctrl,
    input  t_dims     i_dims,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    input  logic      i_out_ready,
    output t_status   o_status,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic [CNT_W-1:0]      r_cnt_a;
    logic [CNT_W-1:0]      r_cnt_b;
    logic [CNT_W-1:0]      size_a;
    logic [CNT_W-1:0]      size_b;
    logic                  accept;
    logic                  a_full;
    logic                  wr_a;
    logic                  wr_b;

    logic [IDX_W-1:0]      r_i;
    logic [IDX_W-1:0]      r_j;
    logic [IDX_W-1:0]      r_k;
    logic [ADDR_W-1:0]     r_row_base;
    logic [ADDR_W-1:0]     r_addr_a;
    logic [ADDR_W-1:0]     r_addr_b;
    logic [DATA_WIDTH-1:0] rd_a;
    logic [DATA_WIDTH-1:0] rd_b;
    logic [DATA_WIDTH-1:0] r_prod;
    logic [DATA_WIDTH-1:0] r_acc;
    logic                  j_last;
    logic                  i_last;

    logic                  r_out_valid;
    t_out_item             r_out_item;

    assign size_a = CNT_W'(i_dims.r) * CNT_W'(i_dims.n);
    assign size_b = CNT_W'(i_dims.n) * CNT_W'(i_dims.c);

    assign accept = i_in_valid && i_ctrl.in_ready;
    assign a_full = (r_cnt_a >= size_a);
    assign wr_a   = accept && (i_in_item.opcode == OP_ELEM_A) && !a_full;
    assign wr_b   = accept && (i_in_item.opcode == OP_ELEM_B) && a_full && (r_cnt_b < size_b);

    assign j_last = ({1'b0, r_j} == i_dims.c - DIM_W'(1));
    assign i_last = ({1'b0, r_i} == i_dims.r - DIM_W'(1));

    // B element that completes (or finds full) store B starts the run
    assign o_status.trig     = accept && (i_in_item.opcode == OP_ELEM_B) && a_full
                               && ((r_cnt_b + CNT_W'(1)) >= size_b);
    assign o_status.k_more   = ({1'b0, r_k} != i_dims.n - DIM_W'(1));
    assign o_status.last     = i_last && j_last;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (wr_a),
        .i_waddr (r_cnt_a[ADDR_W-1:0]),
        .i_wdata (i_in_item.element),
        .i_re    (i_ctrl.rd),
        .i_raddr (r_addr_a),
        .o_rdata (rd_a)
    );

    imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (wr_b),
        .i_waddr (r_cnt_b[ADDR_W-1:0]),
        .i_wdata (i_in_item.element),
        .i_re    (i_ctrl.rd),
        .i_raddr (r_addr_b),
        .o_rdata (rd_b)
    );

    // load counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else if (i_ctrl.init) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else begin
            if (wr_a) begin
                r_cnt_a <= r_cnt_a + CNT_W'(1);
            end
            if (wr_b) begin
                r_cnt_b <= r_cnt_b + CNT_W'(1);
            end
        end
    end

    // index walk and MAC
    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_row_base <= '0;
            r_addr_a   <= '0;
            r_addr_b   <= '0;
            r_acc      <= '0;
        end
        if (i_ctrl.mul) begin
            r_prod <= rd_a * rd_b;
        end
        if (i_ctrl.acc) begin
            r_acc    <= r_acc + r_prod;
            r_k      <= r_k + IDX_W'(1);
            r_addr_a <= r_addr_a + ADDR_W'(1);
            r_addr_b <= r_addr_b + ADDR_W'(i_dims.c);
        end
        if (i_ctrl.advance) begin
            r_k   <= '0;
            r_acc <= '0;
            if (j_last) begin
                r_i        <= r_i + IDX_W'(1);
                r_j        <= '0;
                r_row_base <= r_row_base + ADDR_W'(i_dims.n);
                r_addr_a   <= r_row_base + ADDR_W'(i_dims.n);
                r_addr_b   <= '0;
            end else begin
                r_j      <= r_j + IDX_W'(1);
                r_addr_a <= r_row_base;
                r_addr_b <= ADDR_W'(r_j) + ADDR_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_out_item.product_value <= r_acc;
            r_out_item.out_row       <= r_i;
            r_out_item.out_col       <= r_j;
            r_out_item.last          <= i_last && j_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/core/integer_matrix_multiply_unit.sv
// Top level of the integer matrix multiply unit: configuration registers and block wiring.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_item): opcode 0 loads the next element of A
//    (rows_a x inner_dim, row-major), opcode 1 the next element of B (inner_dim x cols_b).
//    B items sent before A is full are dropped; A items beyond a full A are dropped.
//  - The B item that fills B starts the run. The input is held off (o_in_ready low) until
//    the last product item has gone into the result register.
//  - Output channel (o_out_valid / i_out_ready / o_out_item): rows_a x cols_b items in
//    row-major order, 32-bit wrapped sums with row/col index; last marks the final item.
//  - Load rate: one element per cycle while the unit is idle.
//  - Run: a start step, then for each product item read, multiply and accumulate steps
//    for every inner_dim term on the single multiplier, an emit step and, except after the final
//    item, an index-advance step.
//  - A stalled receiver holds the sequencer in its emit step; the result register keeps
//    its item until taken, so nothing is lost.
//  - Reset (synchronous, active low): dimensions return to 8, load counts to zero, no result
//    pending. Stores are not cleared; only written entries are read.
//  - Configuration (i_cfg_we / i_cfg_idx / i_cfg_data): write while idle only. A value of 0
//    acts as 1, values above 8 act as 8.
module integer_matrix_multiply_unit import imm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    logic [DIM_W-1:0] r_rows_a;
    logic [DIM_W-1:0] r_inner_dim;
    logic [DIM_W-1:0] r_cols_b;
    t_dims            dims;
    t_ctrl            ctrl;
    t_status          status;

    // Configuration registers; index 3 is not mapped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_W'(MAX_DIM);
            r_inner_dim <= DIM_W'(MAX_DIM);
            r_cols_b    <= DIM_W'(MAX_DIM);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                REG_INNER_DIM: r_inner_dim <= i_cfg_data;
                REG_COLS_B:    r_cols_b    <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Clamp dimensions into 1..MAX_DIM
    assign dims.r = eff_dim(r_rows_a);
    assign dims.n = eff_dim(r_inner_dim);
    assign dims.c = eff_dim(r_cols_b);

    imm_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    imm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_dims      (dims),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // Input is taken only in the idle step of the microprogram
    assign o_in_ready = ctrl.in_ready;

endmodule
